// File: rtl/tmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_pkg: shared types and constants of the timer request table
// entry layout, result kinds, opcodes, sequencer states, compare results
// ----------------------------------------------------------------------------
package tmr_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [1:0] {
        KIND_FIRED   = 2'd0,
        KIND_RESCHED = 2'd1,
        KIND_ADDED   = 2'd2,
        KIND_FULL    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    // one table slot; expiry is start + duration, kept so a scan needs no add
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] start;
        logic [31:0] dur;
        logic [31:0] expiry;
    } t_entry;

    typedef struct packed {
        logic hit;      // entry id equals requested id
        logic due;      // entry expiry has been reached
        logic better;   // entry beats the best due entry so far
    } t_cmp;

endpackage

// File: rtl/tmr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_ram: timer entry storage
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tmr_ram #(
    parameter int DEPTH = tmr_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tmr_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output tmr_pkg::t_entry o_rdata
);

    tmr_pkg::t_entry r_mem [DEPTH];
    tmr_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tmr_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_cmp: shared compare unit
// id match, wrap-safe due test and earliest-expiry test for one entry
// ----------------------------------------------------------------------------
module tmr_cmp (
    input  tmr_pkg::t_entry i_entry,
    input  logic [31:0]     i_tid,
    input  logic [31:0]     i_now,
    input  logic [31:0]     i_best_t,
    input  logic            i_found,
    output tmr_pkg::t_cmp   o_res
);

    logic [31:0] now_diff;
    logic [31:0] best_diff;

    assign now_diff  = i_now - i_entry.expiry;
    assign best_diff = i_best_t - i_entry.expiry;

    // ties go to the later slot, so an equal expiry replaces the best
    assign o_res.hit    = (i_entry.id == i_tid);
    assign o_res.due    = ~now_diff[31];
    assign o_res.better = ~i_found | ~best_diff[31];

endmodule

// File: rtl/timer_request_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_request_table: table of pending one-shot timers
// requests add or reschedule timers, ticks fire every due timer in expiry order
// ----------------------------------------------------------------------------
//
//  channel   ports                                          handshake
//  --------  ---------------------------------------------  -----------------
//  command   i_opcode i_timer_id i_duration_ms i_now_ms     start, busy
//  result    o_kind o_fired_id o_start_ms o_delay_ms        o_strobe (1 cycle)
//            o_fire_time_ms o_last
//
//  - a command transaction is taken when start is high and busy is low
//  - request: a scan over the n valid slots (ending early when the id is
//    found), one result
//  - tick: each fired timer costs a scan plus a compaction sweep over the
//    m slots behind it; a tick with nothing due costs a single scan
//  - the single read port of the entry memory serves all scans and sweeps
//  - reset empties the table at once; results cannot be held off by the
//    receiver, each is shown for exactly one cycle
//
module timer_request_table #(
    parameter int TABLE_DEPTH = tmr_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [31:0] i_timer_id,
    input  logic [31:0] i_duration_ms,
    input  logic [31:0] i_now_ms,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [31:0] o_fired_id,
    output logic [31:0] o_start_ms,
    output logic [31:0] o_delay_ms,
    output logic [31:0] o_fire_time_ms,
    output logic        o_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    // sequencer state
    tmr_pkg::t_state r_state, n_state;

    // latched command
    logic            r_op;
    logic [31:0]     r_id;
    logic [31:0]     r_dur;
    logic [31:0]     r_now;

    // table occupancy: valid entries always fill slots 0 .. count-1
    logic [CW-1:0]   r_count;

    // scan / sweep pointer and read pipeline tag
    logic [CW-1:0]   r_idx;
    logic            r_rd_vld;
    logic [CW-1:0]   r_rd_idx;

    // best due entry of the current pick
    logic            r_found;
    logic [AW-1:0]   r_best_idx;
    tmr_pkg::t_entry r_best;

    // last picked entry, held until we know whether another one follows
    logic            r_pend_vld;
    tmr_pkg::t_entry r_pend;

    // result registers
    logic            r_strobe;
    tmr_pkg::t_kind  r_kind;
    logic [31:0]     r_oid;
    logic [31:0]     r_ostart;
    logic [31:0]     r_odly;
    logic [31:0]     r_ofire;
    logic            r_olast;

    // control from the output decode
    logic            rd_en;
    logic            we;
    logic [AW-1:0]   waddr;
    tmr_pkg::t_entry wdata;
    logic            emit;
    logic            emit_from_pend;
    logic            emit_last;
    tmr_pkg::t_kind  emit_kind;

    tmr_pkg::t_entry rd_data;
    tmr_pkg::t_entry new_entry;
    tmr_pkg::t_cmp   cmp;

    logic            accept;
    logic            scan_end;
    logic            req_hit;
    logic            is_req;

    assign accept   = start && (r_state == tmr_pkg::ST_IDLE);
    assign busy     = (r_state != tmr_pkg::ST_IDLE);
    assign is_req   = (r_op == tmr_pkg::OP_REQUEST);
    // all reads issued and the last read word consumed
    assign scan_end = (r_idx == r_count) && !r_rd_vld;
    assign req_hit  = (r_state == tmr_pkg::ST_SCAN) && is_req && r_rd_vld && cmp.hit;

    assign new_entry.id     = r_id;
    assign new_entry.start  = r_now;
    assign new_entry.dur    = r_dur;
    assign new_entry.expiry = r_now + r_dur;

    tmr_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    tmr_cmp u_cmp (
        .i_entry  (rd_data),
        .i_tid    (r_id),
        .i_now    (r_now),
        .i_best_t (r_best.expiry),
        .i_found  (r_found),
        .o_res    (cmp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tmr_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = tmr_pkg::ST_SCAN;
                end
            end
            tmr_pkg::ST_SCAN: begin
                if (req_hit) begin
                    n_state = tmr_pkg::ST_IDLE;
                end else if (scan_end) begin
                    if (!is_req && r_found) begin
                        n_state = tmr_pkg::ST_SHIFT;
                    end else begin
                        n_state = tmr_pkg::ST_IDLE;
                    end
                end
            end
            tmr_pkg::ST_SHIFT: begin
                if (scan_end) begin
                    n_state = tmr_pkg::ST_SCAN;
                end
            end
            default: n_state = tmr_pkg::ST_IDLE;
        endcase
    end

    // control decode
    always_comb begin
        rd_en          = 1'b0;
        we             = 1'b0;
        waddr          = r_rd_idx[AW-1:0];
        wdata          = new_entry;
        emit           = 1'b0;
        emit_from_pend = 1'b0;
        emit_last      = 1'b1;
        emit_kind      = tmr_pkg::KIND_FIRED;
        case (r_state)
            tmr_pkg::ST_SCAN: begin
                rd_en = (r_idx < r_count) && !req_hit;
                if (req_hit) begin
                    // reschedule in place
                    we        = 1'b1;
                    emit      = 1'b1;
                    emit_kind = tmr_pkg::KIND_RESCHED;
                end else if (scan_end) begin
                    if (is_req) begin
                        emit = 1'b1;
                        if (r_count == FULL_COUNT) begin
                            emit_kind = tmr_pkg::KIND_FULL;
                        end else begin
                            we        = 1'b1;
                            waddr     = r_count[AW-1:0];
                            emit_kind = tmr_pkg::KIND_ADDED;
                        end
                    end else begin
                        // flush the previous pick; last only if nothing else is due
                        emit           = r_pend_vld;
                        emit_from_pend = 1'b1;
                        emit_last      = !r_found;
                    end
                end
            end
            tmr_pkg::ST_SHIFT: begin
                // move each entry behind the fired one down a slot
                rd_en = (r_idx < r_count);
                if (r_rd_vld) begin
                    we    = 1'b1;
                    waddr = r_rd_idx[AW-1:0] - 1'b1;
                    wdata = rd_data;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tmr_pkg::ST_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            r_strobe <= emit;
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            case (r_state)
                tmr_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_pend_vld <= 1'b0;
                    end
                end
                tmr_pkg::ST_SCAN: begin
                    if (!is_req && r_rd_vld && cmp.due && cmp.better) begin
                        r_found <= 1'b1;
                    end
                    if (scan_end && !req_hit) begin
                        if (is_req) begin
                            if (r_count != FULL_COUNT) begin
                                r_count <= r_count + 1'b1;
                            end
                        end else if (r_found) begin
                            r_pend_vld <= 1'b1;
                            r_found    <= 1'b0;
                            r_idx      <= CW'(r_best_idx) + 1'b1;
                        end
                    end
                end
                tmr_pkg::ST_SHIFT: begin
                    if (scan_end) begin
                        r_count <= r_count - 1'b1;
                        r_idx   <= '0;
                    end
                end
                default: begin
                    r_idx <= '0;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (accept) begin
            r_op  <= i_opcode;
            r_id  <= i_timer_id;
            r_dur <= i_duration_ms;
            r_now <= i_now_ms;
        end
        if (r_state == tmr_pkg::ST_SCAN && !is_req && r_rd_vld && cmp.due && cmp.better) begin
            r_best     <= rd_data;
            r_best_idx <= r_rd_idx[AW-1:0];
        end
        if (r_state == tmr_pkg::ST_SCAN && !is_req && scan_end && r_found) begin
            r_pend <= r_best;
        end
        if (emit) begin
            r_kind  <= emit_kind;
            r_olast <= emit_last;
            if (emit_from_pend) begin
                r_oid    <= r_pend.id;
                r_ostart <= r_pend.start;
                r_odly   <= r_pend.dur;
                r_ofire  <= r_now;
            end else begin
                r_oid    <= r_id;
                r_ostart <= r_now;
                r_odly   <= r_dur;
                r_ofire  <= '0;
            end
        end
    end

    assign o_strobe       = r_strobe;
    assign o_kind         = r_kind;
    assign o_fired_id     = r_oid;
    assign o_start_ms     = r_ostart;
    assign o_delay_ms     = r_odly;
    assign o_fire_time_ms = r_ofire;
    assign o_last         = r_olast;

    // occupancy never exceeds the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("table count beyond depth");

    // a taken command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("not busy after command transaction");

    // a result that is not the last one means more work is still going on
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("run ended without last mark");

    // request results are single and always carry the last mark
    a_req_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind != tmr_pkg::KIND_FIRED)) |-> o_last)
        else $error("request result without last mark");

endmodule
